// ===== rtl/core/brm_pkg.sv =====
// brm_pkg: shared widths, defaults and the controller-to-datapath command type
// for the radix-2 Booth multiplier. No dependencies.
package brm_pkg;

    localparam int unsigned WIDTH_DEF = 16;   // Booth word width
    localparam int unsigned OPND_W    = 16;   // operand port width
    localparam int unsigned PROD_W    = 32;   // product port width

    typedef struct packed {
        logic load;      // take fresh operands, clear accumulator
        logic step;      // one Booth add/sub and arithmetic shift
        logic capture;   // copy finished product into the output register
    } t_brm_cmd;

endpackage

// ===== rtl/core/brm_datapath.sv =====
// brm_datapath: Booth accumulator, multiplier shift register, multiplicand
// hold and product output register. Uses brm_pkg; driven by brm_ctrl.
module brm_datapath #(
    parameter int unsigned WIDTH = brm_pkg::WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  brm_pkg::t_brm_cmd                    i_cmd,
    input  logic signed [brm_pkg::OPND_W-1:0]    i_multiplicand,
    input  logic signed [brm_pkg::OPND_W-1:0]    i_multiplier,
    output logic signed [brm_pkg::PROD_W-1:0]    o_product
);

    localparam int unsigned OW = brm_pkg::OPND_W;
    localparam int unsigned PW = brm_pkg::PROD_W;

    logic [WIDTH:0]   r_acc;
    logic [WIDTH-1:0] r_mq;
    logic             r_prev;
    logic [WIDTH-1:0] r_mcand;
    logic [PW-1:0]    r_product;

    logic [WIDTH-1:0] w_mcand_ld;
    logic [WIDTH-1:0] w_mult_ld;
    logic [WIDTH:0]   w_m_ext;
    logic [WIDTH:0]   w_sum;
    logic [2*WIDTH-1:0] w_p2w;
    logic [PW-1:0]    w_prod;

    // Operands cut to WIDTH bits or sign-extended up to it
    generate
        if (WIDTH <= OW) begin : g_narrow_ld
            assign w_mcand_ld = i_multiplicand[WIDTH-1:0];
            assign w_mult_ld  = i_multiplier[WIDTH-1:0];
        end else begin : g_wide_ld
            assign w_mcand_ld = {{(WIDTH-OW){i_multiplicand[OW-1]}}, i_multiplicand};
            assign w_mult_ld  = {{(WIDTH-OW){i_multiplier[OW-1]}}, i_multiplier};
        end
    endgenerate

    assign w_m_ext = {r_mcand[WIDTH-1], r_mcand};

    always_comb begin
        case ({r_mq[0], r_prev})
            2'b10:   w_sum = r_acc - w_m_ext;
            2'b01:   w_sum = r_acc + w_m_ext;
            default: w_sum = r_acc;
        endcase
    end

    assign w_p2w = {r_acc[WIDTH-1:0], r_mq};

    generate
        if (2*WIDTH >= PW) begin : g_prod_trunc
            assign w_prod = w_p2w[PW-1:0];
        end else begin : g_prod_sext
            assign w_prod = {{(PW-2*WIDTH){w_p2w[2*WIDTH-1]}}, w_p2w};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        // capture reads the finished word before a same-cycle load replaces it
        if (i_cmd.capture) begin
            r_product <= w_prod;
        end
        if (i_cmd.load) begin
            r_mcand <= w_mcand_ld;
            r_mq    <= w_mult_ld;
            r_acc   <= '0;
            r_prev  <= 1'b0;
        end else if (i_cmd.step) begin
            r_acc  <= {w_sum[WIDTH], w_sum[WIDTH:1]};
            r_mq   <= {w_sum[0], r_mq[WIDTH-1:1]};
            r_prev <= r_mq[0];
        end
    end

    assign o_product = r_product;

endmodule

// ===== rtl/core/brm_ctrl.sv =====
// brm_ctrl: sequencer for the Booth multiplier - step counter, handshakes and
// output valid. Uses brm_pkg; issues commands to brm_datapath.
module brm_ctrl #(
    parameter int unsigned WIDTH = brm_pkg::WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output brm_pkg::t_brm_cmd o_cmd
);

    localparam int unsigned CW = $clog2(WIDTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid, n_out_valid;

    logic w_can_capture;
    logic w_accept;
    logic w_last;

    assign w_can_capture = !r_out_valid || !i_stall;
    assign o_stall  = !((r_state == S_IDLE) || ((r_state == S_DONE) && w_can_capture));
    assign w_accept = i_valid && !o_stall;
    assign w_last   = (r_count == CW'(WIDTH-1));

    always_comb begin
        o_cmd.load    = w_accept;
        o_cmd.step    = (r_state == S_RUN);
        o_cmd.capture = (r_state == S_DONE) && w_can_capture;

        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;

        // beat taken downstream
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RUN;
                    n_count = '0;
                end
            end
            S_RUN: begin
                n_count = r_count + 1'b1;
                if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_can_capture) begin
                    n_out_valid = 1'b1;
                    n_count     = '0;
                    n_state     = w_accept ? S_RUN : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== rtl/core/booth_radix2_multiplier_unit.sv =====
// booth_radix2_multiplier_unit: top level, joins brm_ctrl and brm_datapath.
// Uses brm_pkg.
//
// Signed 16 x 16 multiplier giving a full 32-bit signed product by the
// radix-2 Booth recurrence, one add/subtract-and-shift step per clock. An
// operand beat is loaded on acceptance, then WIDTH steps run in the shared
// adder, then the product moves to an output register. Back to back, a new
// beat is taken in the same cycle the previous product is captured, so a new
// pair is accepted only after the previous one has run all its steps; the
// step counter over the single Booth adder sets that pace. o_valid rises
// together with the product register load. The output register lets one
// finished product wait while the next pair is being worked on.
module booth_radix2_multiplier_unit #(
    parameter int unsigned WIDTH = brm_pkg::WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [brm_pkg::OPND_W-1:0]    i_multiplicand,
    input  logic signed [brm_pkg::OPND_W-1:0]    i_multiplier,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [brm_pkg::PROD_W-1:0]    o_product
);

    brm_pkg::t_brm_cmd w_cmd;

    brm_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    brm_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .i_multiplicand (i_multiplicand),
        .i_multiplier   (i_multiplier),
        .o_product      (o_product)
    );

endmodule
